[sv/bmmr_pkg.sv]
// Shared package for the block min/max/RMS decimator.
// Holds fixed widths, beat types and the controller/datapath command bundles.
// No dependencies.
package bmmr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_BITS       = 16;
    localparam int ENERGY_BITS    = 46;
    localparam int ROOT_BITS      = ENERGY_BITS / 2;
    localparam int DIV_STEPS      = ENERGY_BITS;
    localparam int ROOT_STEPS     = ROOT_BITS;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] block_min;
        logic signed [SAMPLE_BITS-1:0] block_max;
        logic        [SAMPLE_BITS-1:0] block_rms;
        logic                          final_point;
    } t_out_beat;

    typedef struct packed {
        logic accept;
        logic square;
        logic accum;
        logic div_step;
        logic root_step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic can_pub;
    } t_dp_sts;

endpackage

[sv/bmmr_ctrl.sv]
// Sequencer for the block min/max/RMS decimator.
// Squares and accumulates each sample; a closing one adds serial divide and root.
// Depends on bmmr_pkg.
module bmmr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bmmr_pkg::t_dp_sts  i_sts,
    output bmmr_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_DIV,
        S_ROOT,
        S_PUB
    } t_state;

    localparam logic [bmmr_pkg::STEP_W-1:0] DIV_LAST  =
        bmmr_pkg::STEP_W'(bmmr_pkg::DIV_STEPS - 1);
    localparam logic [bmmr_pkg::STEP_W-1:0] ROOT_LAST =
        bmmr_pkg::STEP_W'(bmmr_pkg::ROOT_STEPS - 1);

    t_state                      r_state, n_state;
    logic [bmmr_pkg::STEP_W-1:0] r_step,  n_step;
    logic                        r_in_stall, n_in_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_step = '0;
                if (i_sts.close) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_step  = '0;
                    n_state = S_ROOT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROOT: begin
                if (r_step == ROOT_LAST) begin
                    n_step  = '0;
                    n_state = S_PUB;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_PUB: begin
                if (i_sts.can_pub) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_in_stall <= n_in_stall;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = i_in_valid && !r_in_stall;
        o_cmd.square    = (r_state == S_SQ);
        o_cmd.accum     = (r_state == S_ACC);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.publish   = (r_state == S_PUB);
    end

    assign o_in_stall = r_in_stall;

    a_pub_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUB) && i_sts.can_pub |=> (r_state == S_IDLE) && !r_in_stall)
        else $error("controller did not return to idle after publishing a point");

endmodule

[sv/bmmr_datapath.sv]
// Datapath for the block min/max/RMS decimator: block statistics, squarer,
// restoring divider and digit-by-digit square root, output register.
// Depends on bmmr_pkg.
module bmmr_datapath #(
    parameter int COUNT_BITS = bmmr_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bmmr_pkg::t_dp_cmd                 i_cmd,
    output bmmr_pkg::t_dp_sts                 o_sts,
    input  bmmr_pkg::t_in_beat                i_in_beat,
    input  logic                              i_cfg_we,
    input  logic [bmmr_pkg::CFG_BITS-1:0]     i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bmmr_pkg::t_out_beat               o_out_beat
);

    localparam int SB    = bmmr_pkg::SAMPLE_BITS;
    localparam int EB    = bmmr_pkg::ENERGY_BITS;
    localparam int RB    = bmmr_pkg::ROOT_BITS;
    localparam int CB    = bmmr_pkg::CFG_BITS;
    localparam int SQ_W  = 2 * SB;
    localparam int SUM_W = ((SQ_W > EB) ? SQ_W : EB) + 1;
    localparam int CMP_W = (COUNT_BITS > CB) ? COUNT_BITS : CB;

    localparam logic signed [SB-1:0]   SMAXV = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0]   SMINV = {1'b1, {(SB-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0]  CMAX  = {COUNT_BITS{1'b1}};
    localparam logic [EB-1:0]          EMAX  = {EB{1'b1}};

    // Configuration and block statistics.
    logic [CB-1:0]           r_spp;
    logic signed [SB-1:0]    r_min, r_max;
    logic [EB-1:0]           r_energy;
    logic [COUNT_BITS-1:0]   r_count;
    logic                    r_out_valid;

    // Working registers.
    logic signed [SB-1:0]    r_sample;
    logic                    r_last;
    logic [SQ_W-1:0]         r_sq;
    logic [EB-1:0]           r_dvd;
    logic [COUNT_BITS-1:0]   r_div;
    logic [COUNT_BITS-1:0]   r_rem;
    logic [RB:0]             r_rt_rem;
    logic [RB-1:0]           r_root;
    bmmr_pkg::t_out_beat     r_out;

    logic [SB-1:0]           mag;
    logic [SQ_W-1:0]         sq_full;
    logic [SUM_W-1:0]        sum;
    logic [EB-1:0]           energy_nx;
    logic [COUNT_BITS-1:0]   cnt_nx;
    logic [CB-1:0]           len;
    logic signed [SB-1:0]    min_nx, max_nx;
    logic                    close;
    logic                    can_pub;
    logic                    pub_fire;
    logic [COUNT_BITS:0]     rem_sh, rem_sub;
    logic                    div_ge;
    logic [RB+2:0]           rt_cur, rt_trial, rt_sub;
    logic                    rt_ge;

    assign mag     = r_sample[SB-1] ? SB'(-r_sample) : r_sample;
    assign sq_full = SQ_W'(mag) * SQ_W'(mag);

    assign sum       = SUM_W'(r_energy) + SUM_W'(r_sq);
    assign energy_nx = (sum > SUM_W'(EMAX)) ? EMAX : sum[EB-1:0];
    assign cnt_nx    = (r_count == CMAX) ? r_count : r_count + 1'b1;
    assign len       = (r_spp == '0) ? CB'(1) : r_spp;
    assign min_nx    = (r_sample < r_min) ? r_sample : r_min;
    assign max_nx    = (r_sample > r_max) ? r_sample : r_max;
    assign close     = r_last || (CMP_W'(cnt_nx) >= CMP_W'(len)) || (cnt_nx == CMAX);

    assign can_pub  = !r_out_valid || !i_out_stall;
    assign pub_fire = i_cmd.publish && can_pub;

    // One quotient bit per cycle; quotient bits shift in behind the dividend.
    assign rem_sh  = {r_rem, r_dvd[EB-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    // One root bit per cycle, consuming two radicand bits from the top of r_dvd.
    assign rt_cur   = {r_rt_rem, r_dvd[EB-1:EB-2]};
    assign rt_trial = {1'b0, r_root, 2'b01};
    assign rt_ge    = (rt_cur >= rt_trial);
    assign rt_sub   = rt_cur - rt_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp       <= CB'(1);
            r_min       <= SMAXV;
            r_max       <= SMINV;
            r_energy    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_spp <= i_cfg_data;
            end
            if (i_cmd.accum) begin
                r_min    <= min_nx;
                r_max    <= max_nx;
                r_energy <= energy_nx;
                r_count  <= cnt_nx;
            end else if (pub_fire) begin
                r_min    <= SMAXV;
                r_max    <= SMINV;
                r_energy <= '0;
                r_count  <= '0;
            end
            if (pub_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_in_beat.sample;
            r_last   <= i_in_beat.last;
        end
        if (i_cmd.square) begin
            r_sq <= sq_full;
        end
        if (i_cmd.accum && close) begin
            r_dvd    <= energy_nx;
            r_div    <= cnt_nx;
            r_rem    <= '0;
            r_rt_rem <= '0;
            r_root   <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[EB-2:0], div_ge};
            r_rem <= div_ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        end else if (i_cmd.root_step) begin
            r_dvd    <= {r_dvd[EB-3:0], 2'b00};
            r_rt_rem <= rt_ge ? rt_sub[RB:0] : rt_cur[RB:0];
            r_root   <= {r_root[RB-2:0], rt_ge};
        end
        if (pub_fire) begin
            r_out.block_min   <= r_min;
            r_out.block_max   <= r_max;
            r_out.block_rms   <= SB'(r_root);
            r_out.final_point <= r_last;
        end
    end

    always_comb begin
        o_sts         = '0;
        o_sts.close   = close;
        o_sts.can_pub = can_pub;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_div != '0))
        else $error("divide step started with a zero sample count");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("running minimum exceeds running maximum in a nonempty block");

    a_pub_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pub_fire |=> (r_count == '0) && (r_energy == '0) && r_out_valid)
        else $error("block statistics not cleared after a point was published");

endmodule

[sv/block_min_max_rms.sv]
// Top level of the block min/max/RMS decimator.
// Instantiates bmmr_ctrl and bmmr_datapath; depends on bmmr_pkg.
//
//   Channel  Direction  Handshake                Beat
//   in       sink       i_in_valid / o_in_stall  t_in_beat (sample, last)
//   out      source     o_out_valid / i_out_stall t_out_beat (min, max, rms, final)
//   cfg      sink       i_cfg_valid / o_cfg_ready samples_per_point
//
// A sample that does not close a block passes through capture, square and accumulate.
// A closing sample then goes through a restoring divide (one quotient bit per cycle),
// a square root (one root bit per cycle) and a publish step.
// Reset is synchronous; statistics reset to an empty block and the length to 1.
// The input stalls while a sample is in work; a stalled output holds its point and
// holds the next point in the publish step until the output register is free.
module block_min_max_rms #(
    parameter int COUNT_BITS = bmmr_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bmmr_pkg::t_in_beat                i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bmmr_pkg::t_out_beat               o_out_beat,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bmmr_pkg::CFG_BITS-1:0]     i_cfg_data
);

    bmmr_pkg::t_dp_cmd cmd;
    bmmr_pkg::t_dp_sts sts;

    // The length register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    bmmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bmmr_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
